/* design/i2cbr_pkg.sv */
// i2c bus recovery sequencer package: register indexes, status codes,
// reset values and the configuration struct shared by all design files
// no dependencies
package i2cbr_pkg;

	localparam int unsigned TIMER_BITS_DEF = 24;

	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HALF    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_STRETCH = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_PULSES  = CFG_IDX_W'(3);

	localparam logic [23:0] SETTLE_RST  = 24'd2500000;
	localparam logic [15:0] HALF_RST    = 16'd10;
	localparam logic [23:0] STRETCH_RST = 24'd2000000;
	localparam logic [7:0]  PULSES_RST  = 8'd20;

	typedef logic [1:0] status_t;
	localparam status_t ST_CLEARED   = 2'd0;
	localparam status_t ST_SCL_LOW   = 2'd1;
	localparam status_t ST_STRETCH   = 2'd2;
	localparam status_t ST_SDA_STUCK = 2'd3;

	typedef struct packed {
		logic [23:0] settle_ticks;
		logic [15:0] half_period_ticks;
		logic [23:0] stretch_limit_ticks;
		logic [7:0]  max_pulses;
	} cfg_t;

endpackage

/* design/i2cbr_if.sv */
// channel interfaces of the i2c bus recovery sequencer: tick items,
// result items and configuration writes
// depends on i2cbr_pkg
interface i2cbr_req_if;
	logic valid;
	logic ready;
	logic start_req;
	logic sda_line;
	logic scl_line;
	modport source (output valid, start_req, sda_line, scl_line, input ready);
	modport sink (input valid, start_req, sda_line, scl_line, output ready);
endinterface

interface i2cbr_rsp_if;
	logic valid;
	logic ready;
	logic scl_pull_low;
	logic sda_pull_low;
	logic busy_res;
	logic done_res;
	logic [1:0] status;
	modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res, status,
		input ready);
	modport sink (input valid, scl_pull_low, sda_pull_low, busy_res, done_res, status,
		output ready);
endinterface

interface i2cbr_cfg_if;
	logic valid;
	logic ready;
	logic [i2cbr_pkg::CFG_IDX_W-1:0] index;
	logic [i2cbr_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/i2cbr_cfg_regs.sv */
// configuration register file of the i2c bus recovery sequencer
// depends on i2cbr_pkg and i2cbr_if
module i2cbr_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	i2cbr_cfg_if.sink          cfg,
	output i2cbr_pkg::cfg_t    regs
);
	import i2cbr_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.settle_ticks        <= SETTLE_RST;
			regs_q.half_period_ticks   <= HALF_RST;
			regs_q.stretch_limit_ticks <= STRETCH_RST;
			regs_q.max_pulses          <= PULSES_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_SETTLE:  regs_q.settle_ticks        <= cfg.data[23:0];
				REG_HALF:    regs_q.half_period_ticks   <= cfg.data[15:0];
				REG_STRETCH: regs_q.stretch_limit_ticks <= cfg.data[23:0];
				REG_PULSES:  regs_q.max_pulses          <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

endmodule

/* design/i2cbr_seq.sv */
// bus-clear state machine with its result register, one tick item per cycle while results are taken
// depends on i2cbr_pkg and i2cbr_if
module i2cbr_seq #(
	parameter int unsigned TIMER_BITS = i2cbr_pkg::TIMER_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  i2cbr_pkg::cfg_t regs,
	i2cbr_req_if.sink       req,
	i2cbr_rsp_if.source     rsp
);
	import i2cbr_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_SETTLE     = 4'd1,
		PH_PULSE_LOW  = 4'd2,
		PH_PULSE_HIGH = 4'd3,
		PH_STRETCH    = 4'd4,
		PH_START_LOW  = 4'd5,
		PH_STOP_HIGH  = 4'd6
	} phase_t;

	localparam logic [31:0] TMAX = 32'hFFFF_FFFF >> (32 - TIMER_BITS);

	function automatic logic [TIMER_BITS-1:0] clip(input logic [31:0] v);
		logic [TIMER_BITS-1:0] r;
		if (v > TMAX) r = TMAX[TIMER_BITS-1:0];
		else r = v[TIMER_BITS-1:0];
		return r;
	endfunction

	phase_t                ph_q, ph_d, dec_ph;
	logic [TIMER_BITS-1:0] tmr_q, tmr_d, dec_tmr, tmr_dec;
	logic [TIMER_BITS-1:0] settle_c, half_c, stretch_c;
	logic [7:0]            pl_q, pl_d, pl_src, dec_pl;
	status_t               st_q, st_d, dec_st;
	logic                  done_d, dec_done, tmr_zero;
	logic                  accept;
	logic                  out_valid_q;
	logic                  scl_pull_q, sda_pull_q, busy_q, done_q;
	status_t               status_q;

	assign accept   = req.valid && req.ready;
	assign req.ready = !out_valid_q || rsp.ready;

	assign settle_c  = clip(32'(regs.settle_ticks));
	assign half_c    = clip(32'(regs.half_period_ticks));
	assign stretch_c = clip(32'(regs.stretch_limit_ticks));
	assign tmr_zero  = (tmr_q == '0);
	assign tmr_dec   = tmr_q - 1'b1;
	assign pl_src    = (ph_q == PH_SETTLE) ? regs.max_pulses : pl_q;

	// sda check after the scl line is known free
	always_comb begin
		dec_ph   = ph_q;
		dec_tmr  = tmr_q;
		dec_pl   = pl_src;
		dec_st   = st_q;
		dec_done = 1'b0;
		if (!req.sda_line) begin
			if (pl_src != 8'd0) begin
				dec_pl  = pl_src - 8'd1;
				dec_ph  = PH_PULSE_LOW;
				dec_tmr = half_c;
			end else begin
				dec_ph   = PH_IDLE;
				dec_tmr  = '0;
				dec_st   = ST_SDA_STUCK;
				dec_done = 1'b1;
			end
		end else begin
			dec_ph  = PH_START_LOW;
			dec_tmr = half_c;
		end
	end

	always_comb begin
		ph_d   = ph_q;
		tmr_d  = tmr_q;
		pl_d   = pl_q;
		st_d   = st_q;
		done_d = 1'b0;
		case (ph_q)
			PH_IDLE: begin
				if (req.start_req) begin
					ph_d  = PH_SETTLE;
					tmr_d = settle_c;
				end
			end
			PH_SETTLE: begin
				if (!tmr_zero) begin
					tmr_d = tmr_dec;
				end else if (!req.scl_line) begin
					ph_d   = PH_IDLE;
					tmr_d  = '0;
					st_d   = ST_SCL_LOW;
					done_d = 1'b1;
				end else begin
					ph_d = dec_ph; tmr_d = dec_tmr; pl_d = dec_pl;
					st_d = dec_st; done_d = dec_done;
				end
			end
			PH_PULSE_LOW, PH_START_LOW: begin
				if (!tmr_zero) begin
					tmr_d = tmr_dec;
				end else begin
					ph_d  = (ph_q == PH_PULSE_LOW) ? PH_PULSE_HIGH : PH_STOP_HIGH;
					tmr_d = half_c;
				end
			end
			PH_PULSE_HIGH: begin
				if (!tmr_zero) begin
					tmr_d = tmr_dec;
				end else if (req.scl_line) begin
					ph_d = dec_ph; tmr_d = dec_tmr; pl_d = dec_pl;
					st_d = dec_st; done_d = dec_done;
				end else begin
					ph_d  = PH_STRETCH;
					tmr_d = stretch_c;
				end
			end
			PH_STRETCH: begin
				if (req.scl_line) begin
					ph_d = dec_ph; tmr_d = dec_tmr; pl_d = dec_pl;
					st_d = dec_st; done_d = dec_done;
				end else if (tmr_zero) begin
					ph_d   = PH_IDLE;
					tmr_d  = '0;
					st_d   = ST_STRETCH;
					done_d = 1'b1;
				end else begin
					tmr_d = tmr_dec;
				end
			end
			PH_STOP_HIGH: begin
				if (!tmr_zero) begin
					tmr_d = tmr_dec;
				end else begin
					ph_d   = PH_IDLE;
					tmr_d  = '0;
					st_d   = ST_CLEARED;
					done_d = 1'b1;
				end
			end
			default: begin
				ph_d  = PH_IDLE;
				tmr_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_IDLE;
			tmr_q       <= '0;
			pl_q        <= '0;
			st_q        <= ST_CLEARED;
			out_valid_q <= 1'b0;
			scl_pull_q  <= 1'b0;
			sda_pull_q  <= 1'b0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= ST_CLEARED;
		end else begin
			if (accept) begin
				ph_q        <= ph_d;
				tmr_q       <= tmr_d;
				pl_q        <= pl_d;
				st_q        <= st_d;
				out_valid_q <= 1'b1;
				scl_pull_q  <= (ph_d == PH_PULSE_LOW);
				sda_pull_q  <= (ph_d == PH_START_LOW);
				busy_q      <= (ph_d != PH_IDLE);
				done_q      <= done_d;
				status_q    <= st_d;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.scl_pull_low = scl_pull_q;
	assign rsp.sda_pull_low = sda_pull_q;
	assign rsp.busy_res     = busy_q;
	assign rsp.done_res     = done_q;
	assign rsp.status       = status_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> !busy_q)
		else $error("done item reports busy");

	a_pulls_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(scl_pull_q && sda_pull_q))
		else $error("both lines pulled low");

	a_start_enters_settle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ph_q == PH_IDLE && req.start_req) |=> (ph_q == PH_SETTLE && busy_q))
		else $error("start not taken from idle");

	a_pulses_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_PULSE_LOW || ph_q == PH_PULSE_HIGH || ph_q == PH_STRETCH)
		|-> (pl_q < regs.max_pulses))
		else $error("pulse count out of range");

endmodule

/* design/i2c_bus_recovery_sequencer_core.sv */
// i2c bus-clear recovery sequencer, top level
// result: a tick item's result is registered and offered in the cycle after it is accepted
// throughput: one tick item per cycle while results are taken; the result register frees as its item is taken
// reset: arst_n asynchronous, idle phase, status 0, registers at their defaults
// depends on i2cbr_pkg, i2cbr_if, i2cbr_cfg_regs and i2cbr_seq
module i2c_bus_recovery_sequencer_core #(
	parameter int unsigned TIMER_BITS = i2cbr_pkg::TIMER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	i2cbr_req_if.sink   req,
	i2cbr_rsp_if.source rsp,
	i2cbr_cfg_if.sink   cfg
);
	import i2cbr_pkg::*;

	cfg_t regs;

	i2cbr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	i2cbr_seq #(
		.TIMER_BITS (TIMER_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

/* tb/sv/i2c_bus_recovery_sequencer_core_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for the i2c bus-clear recovery sequencer: drives tick items,
// predicts every result item with its own sequencer model and compares field by field
// depends on i2cbr_pkg, i2cbr_if and i2c_bus_recovery_sequencer_core
module i2c_bus_recovery_sequencer_core_test;
	import i2cbr_pkg::*;

	localparam int IDLE_PCT = 31;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 500;
	localparam int MAX_SHOWN = 10;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_PULSES + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST = '1;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SETTLE,
		PH_LOW,
		PH_HIGH,
		PH_STRETCH,
		PH_START,
		PH_STOP
	} seq_phase_t;

	typedef struct packed {
		logic    scl_pull_low;
		logic    sda_pull_low;
		logic    busy_res;
		logic    done_res;
		status_t status;
	} line_ctl_t;

	logic clk = 1'b0;
	logic arst_n;
	int idle_pct = IDLE_PCT;
	int fail_count = 0;
	int items_sent = 0;
	int stall_cycles = 0;
	line_ctl_t seq_outputs_due[$];

	cfg_t cur_cfg = '{SETTLE_RST, HALF_RST, STRETCH_RST, PULSES_RST};
	seq_phase_t ph = PH_IDLE;
	logic [TIMER_BITS_DEF-1:0] tmr = '0;
	logic [7:0] pulses = '0;
	status_t last_st = ST_CLEARED;

	i2cbr_req_if req();
	i2cbr_rsp_if rsp();
	i2cbr_cfg_if cfg();

	i2c_bus_recovery_sequencer_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void end_seq(input status_t code);
		ph = PH_IDLE;
		tmr = '0;
		last_st = code;
	endfunction

	function automatic logic sda_branch(input logic sda);
		sda_branch = 1'b0;
		if (!sda) begin
			if (pulses != 0) begin
				pulses = pulses - 1'b1;
				ph = PH_LOW;
				tmr = TIMER_BITS_DEF'(cur_cfg.half_period_ticks);
			end else begin
				end_seq(ST_SDA_STUCK);
				sda_branch = 1'b1;
			end
		end else begin
			ph = PH_START;
			tmr = TIMER_BITS_DEF'(cur_cfg.half_period_ticks);
		end
	endfunction

	function automatic line_ctl_t bus_clear_step(input logic s, input logic sda, input logic scl);
		logic done;
		line_ctl_t r;
		done = 1'b0;
		case (ph)
		PH_IDLE: begin
			if (s) begin
				ph = PH_SETTLE;
				tmr = cur_cfg.settle_ticks;
			end
		end
		PH_SETTLE: begin
			if (tmr != 0) begin
				tmr = tmr - 1'b1;
			end else if (!scl) begin
				end_seq(ST_SCL_LOW);
				done = 1'b1;
			end else begin
				pulses = cur_cfg.max_pulses;
				done = sda_branch(sda);
			end
		end
		PH_LOW: begin
			if (tmr != 0) begin
				tmr = tmr - 1'b1;
			end else begin
				ph = PH_HIGH;
				tmr = TIMER_BITS_DEF'(cur_cfg.half_period_ticks);
			end
		end
		PH_HIGH: begin
			if (tmr != 0) begin
				tmr = tmr - 1'b1;
			end else if (scl) begin
				done = sda_branch(sda);
			end else begin
				ph = PH_STRETCH;
				tmr = cur_cfg.stretch_limit_ticks;
			end
		end
		PH_STRETCH: begin
			if (scl) begin
				done = sda_branch(sda);
			end else if (tmr == 0) begin
				end_seq(ST_STRETCH);
				done = 1'b1;
			end else begin
				tmr = tmr - 1'b1;
			end
		end
		PH_START: begin
			if (tmr != 0) begin
				tmr = tmr - 1'b1;
			end else begin
				ph = PH_STOP;
				tmr = TIMER_BITS_DEF'(cur_cfg.half_period_ticks);
			end
		end
		PH_STOP: begin
			if (tmr != 0) begin
				tmr = tmr - 1'b1;
			end else begin
				end_seq(ST_CLEARED);
				done = 1'b1;
			end
		end
		default: begin
			ph = PH_IDLE;
			tmr = '0;
		end
		endcase
		r.scl_pull_low = (ph == PH_LOW);
		r.sda_pull_low = (ph == PH_START);
		r.busy_res = (ph != PH_IDLE);
		r.done_res = done;
		r.status = last_st;
		return r;
	endfunction

	function automatic logic line_level(input int low_pct);
		return $urandom_range(99) >= low_pct;
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(4))
		0: return 0;
		1: return 10;
		2: return 50;
		3: return 90;
		default: return 100;
		endcase
	endfunction

	task automatic send_tick(input logic s, input logic sda, input logic scl);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.start_req <= s;
		req.sda_line <= sda;
		req.scl_line <= scl;
		do @(posedge clk); while (!req.ready);
		seq_outputs_due.push_back(bus_clear_step(s, sda, scl));
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req.valid <= 1'b0;
		while (seq_outputs_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
		REG_SETTLE:  cur_cfg.settle_ticks = val[23:0];
		REG_HALF:    cur_cfg.half_period_ticks = val[15:0];
		REG_STRETCH: cur_cfg.stretch_limit_ticks = val[23:0];
		REG_PULSES:  cur_cfg.max_pulses = val[7:0];
		default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// junk above each register width checks the masking
	task automatic set_cfg(input logic [23:0] settle, input logic [15:0] half,
			input logic [23:0] stretch, input logic [7:0] max_p);
		write_reg(REG_SETTLE, {8'($urandom()), settle});
		write_reg(REG_HALF, {16'($urandom()), half});
		write_reg(REG_STRETCH, {8'($urandom()), stretch});
		write_reg(REG_PULSES, {24'($urandom()), max_p});
	endtask

	// one recovery sequence; start is random after the first tick and must be ignored
	task automatic run_seq(input int sda_pct, input int settle_scl_pct, input int stretch_pct);
		send_tick(1'b1, line_level(sda_pct), line_level(settle_scl_pct));
		while (ph != PH_IDLE) begin
			send_tick(1'($urandom_range(1)), line_level(sda_pct),
				line_level((ph == PH_HIGH || ph == PH_STRETCH) ? stretch_pct : settle_scl_pct));
		end
	endtask

	task automatic test_reset_state();
		repeat (4) send_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic test_reset_defaults();
		write_reg(REG_SETTLE, {8'($urandom()), 24'd2});
		run_seq(100, 0, 0);
		run_seq(0, 0, 0);
	endtask

	task automatic test_scl_held_low();
		set_cfg(24'd0, 16'd1, 24'd3, 8'd4);
		run_seq(0, 100, 0);
		set_cfg(24'd5, 16'd2, 24'd3, 8'd4);
		run_seq(50, 100, 0);
	endtask

	task automatic test_clean_bus();
		set_cfg(24'd1, 16'd1, 24'd3, 8'd4);
		run_seq(0, 0, 0);
		set_cfg(24'd0, 16'd0, 24'd0, 8'd0);
		run_seq(0, 0, 0);
	endtask

	task automatic test_sda_stuck();
		set_cfg(24'd0, 16'd0, 24'd2, 8'd3);
		run_seq(100, 0, 0);
		set_cfg(24'd0, 16'd1, 24'd2, 8'd0);
		run_seq(100, 0, 0);
		set_cfg(24'd2, 16'd1, 24'd2, 8'd12);
		run_seq(60, 0, 0);
	endtask

	task automatic test_stretch();
		set_cfg(24'd1, 16'd1, 24'd1, 8'd2);
		run_seq(100, 0, 100);
		set_cfg(24'd0, 16'd0, 24'd0, 8'd2);
		run_seq(100, 0, 100);
		set_cfg(24'd0, 16'd1, 24'd4, 8'd6);
		run_seq(30, 0, 60);
	endtask

	task automatic test_register_extremes();
		write_reg(REG_UNUSED_FIRST, $urandom());
		write_reg(REG_UNUSED_LAST, $urandom());
		write_reg(REG_SETTLE, {8'($urandom()), 24'hFFFFFF});
		repeat (3) send_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
		set_cfg(24'd0, 16'd0, 24'hFFFFFF, 8'hFF);
		run_seq(100, 0, 50);
		// long half period, no idling on either side
		set_cfg(24'd0, 16'd60, 24'd1, 8'd1);
		idle_pct = 0;
		run_seq(0, 0, 0);
		idle_pct = IDLE_PCT;
	endtask

	task automatic test_random_traffic();
		int n0;
		int seq_ticks;
		seq_ticks = 0;
		while (seq_ticks < RANDOM_ITEMS) begin
			if ($urandom_range(3) == 0)
				set_cfg(24'($urandom_range(8)), 16'($urandom_range(3)),
					24'($urandom_range(6)), 8'($urandom_range(8)));
			repeat ($urandom_range(2))
				send_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
			if ($urandom_range(9) == 0)
				wait_drained();
			n0 = items_sent;
			run_seq(pick_pct(), pick_pct(), pick_pct());
			seq_ticks += items_sent - n0;
		end
	endtask

	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		line_ctl_t seen;
		line_ctl_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready) begin
			seen.scl_pull_low = rsp.scl_pull_low;
			seen.sda_pull_low = rsp.sda_pull_low;
			seen.busy_res = rsp.busy_res;
			seen.done_res = rsp.done_res;
			seen.status = rsp.status;
			if (seq_outputs_due.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_SHOWN)
					$display("%0t: unexpected item scl_pull_low=%0b sda_pull_low=%0b",
						$time, seen.scl_pull_low, seen.sda_pull_low,
						" busy=%0b done=%0b status=%0d",
						seen.busy_res, seen.done_res, seen.status);
			end else begin
				want = seq_outputs_due.pop_front();
				if (seen.scl_pull_low !== want.scl_pull_low ||
						seen.sda_pull_low !== want.sda_pull_low ||
						seen.busy_res !== want.busy_res ||
						seen.done_res !== want.done_res ||
						seen.status !== want.status) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN)
						$display("%0t: mismatch exp scl=%0b sda=%0b busy=%0b done=%0b st=%0d,",
							$time, want.scl_pull_low, want.sda_pull_low, want.busy_res,
							want.done_res, want.status,
							" got scl=%0b sda=%0b busy=%0b done=%0b st=%0d",
							seen.scl_pull_low, seen.sda_pull_low,
							seen.busy_res, seen.done_res, seen.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.start_req = 1'b0;
		req.sda_line = 1'b1;
		req.scl_line = 1'b1;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_reset_defaults();
		test_scl_held_low();
		test_clean_bus();
		test_sda_stuck();
		test_stretch();
		test_register_extremes();
		test_random_traffic();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (seq_outputs_due.size() != 0) begin
			fail_count++;
			$display("%0d result items never delivered", seq_outputs_due.size());
		end
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* i2c_bus_recovery_sequencer_core.f */
design/i2cbr_pkg.sv
design/i2cbr_if.sv
design/i2cbr_cfg_regs.sv
design/i2cbr_seq.sv
design/i2c_bus_recovery_sequencer_core.sv
tb/sv/i2c_bus_recovery_sequencer_core_test.sv
